// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with synchronous reset disable
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// same check, message names the response channel
`define ASSERT_RSP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("response channel check failed");

`endif

// ===== sv/shg_pkg.sv =====
// types and constants of the spatial hash grid engine
// no dependencies
package shg_pkg;

   localparam int BUCKET_COUNT     = 256;
   localparam int SLOTS_PER_BUCKET = 4;
   localparam int ID_BITS          = 16;
   localparam int SLOT_COUNT       = BUCKET_COUNT * SLOTS_PER_BUCKET;
   localparam int BUCKET_BITS      = $clog2(BUCKET_COUNT);
   localparam int SLOT_ADDR_BITS   = $clog2(SLOT_COUNT);
   localparam int FILL_BITS        = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int KEY_BITS         = 32;
   localparam int ENTRY_BITS       = KEY_BITS + ID_BITS;

   localparam logic [31:0] PRIME_X = 32'd73856093;
   localparam logic [31:0] PRIME_Y = 32'd19349663;
   localparam logic [3:0]  CELL_SHIFT_RESET = 4'd6;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_MOVED  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NO_MATCH = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        obj_id;
   } req_type;

   typedef struct packed {
      logic [15:0] found_id;
      logic        found;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

// ===== sv/shg_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module shg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/shg_hash_mul.sv =====
// shared hash multiplier: operand times the x or y prime, low 32 bits, registered
// depends on shg_pkg
module shg_hash_mul (
   input  logic        clock,
   input  logic        sel_y,
   input  logic [31:0] operand,
   output logic [31:0] prod
);
   import shg_pkg::*;

   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign prod_in = 32'(operand * (sel_y ? PRIME_Y : PRIME_X));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// ===== sv/spatial_hash_grid_engine.sv =====
// spatial hash grid engine top level: sequencer, bucket store, result register
// depends on shg_pkg, shg_ram, shg_hash_mul
//
// One transaction at a time: busy stays high from the start edge until the final
// result is registered, and that result shows in the first cycle with busy low.
// Each neighbor cell goes through the x and y multiplier states, the key xor,
// a fill read, a read and compare per slot visited and a step to the next
// cell; a remove hit adds a read and a write per compacted slot and one fill
// write. Clear and unused codes go straight to the result; an insert visits
// only the centre cell, remove, query and moved all nine, and moved then inserts.
// The shared hash multiplier and the single-address slot memory set how long busy lasts.
// Results appear on rsp_item for one cycle with rsp_valid high and cannot be
// stalled; a query gives one result per match, or one empty result, last on the
// final one. Clear takes effect at once through per-bucket valid bits.
module spatial_hash_grid_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  shg_pkg::req_type req_item,
   output logic            rsp_valid,
   output shg_pkg::rsp_type rsp_item,
   input  logic            csr_we,
   input  logic [3:0]      csr_wdata
);
   import shg_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_KX   = 12'b000000000010,
      S_KY   = 12'b000000000100,
      S_KEY  = 12'b000000001000,
      S_FILL = 12'b000000010000,
      S_SLOT = 12'b000000100000,
      S_CMP  = 12'b000001000000,
      S_SHRD = 12'b000010000000,
      S_SHWR = 12'b000100000000,
      S_FWR  = 12'b001000000000,
      S_INS  = 12'b010000000000,
      S_DONE = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]  cell_shift_ff, cell_shift_in;
   logic [2:0]  op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic        ins_ff, ins_in;
   logic [31:0] px_ff, px_in, key_ff, key_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in, i_ff, i_in;
   logic        any_ff, any_in, full_ff, full_in;
   logic [ID_BITS-1:0] held_ff, held_in;
   logic        have_ff, have_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [BUCKET_COUNT-1:0] fvalid_ff, fvalid_in;
   logic        fvq_ff;

   logic signed [23:0] sx, sy;
   logic [31:0] nx, ny, prod, mul_op, key_c;
   logic        mul_sel_y;
   logic [BUCKET_BITS-1:0] bucket, fill_raddr;
   logic        fill_we;
   logic [FILL_BITS-1:0] fill_wdata, fill_rdata, fill_cur;
   logic        slot_we;
   logic [FILL_BITS-1:0] slot_idx;
   logic [SLOT_ADDR_BITS-1:0] slot_addr;
   logic [ENTRY_BITS-1:0] slot_wdata, slot_rdata;
   logic [KEY_BITS-1:0] rkey;
   logic [ID_BITS-1:0]  rid;
   logic [FILL_BITS:0]  i_p1, i_p2;
   logic        walk_done;
   logic [1:0]  ndx, ndy;

   assign sx = req_item.pos_x >>> cell_shift_ff;
   assign sy = req_item.pos_y >>> cell_shift_ff;
   assign nx = cx_ff + 32'(dx_ff) - 32'd1;
   assign ny = cy_ff + 32'(dy_ff) - 32'd1;
   assign key_c = px_ff ^ prod;
   assign bucket = key_ff[BUCKET_BITS-1:0];
   assign rkey = slot_rdata[ENTRY_BITS-1:ID_BITS];
   assign rid  = slot_rdata[ID_BITS-1:0];
   assign i_p1 = {1'b0, i_ff} + 1'b1;
   assign i_p2 = {1'b0, i_ff} + 2'd2;
   assign fill_cur = fvq_ff ? fill_rdata : '0;
   assign slot_addr = SLOT_ADDR_BITS'(32'(bucket) * SLOTS_PER_BUCKET + 32'(slot_idx));

   // dx-major neighbor walk
   always_comb begin
      walk_done = 1'b0;
      ndx = dx_ff;
      ndy = dy_ff + 2'd1;
      if (dy_ff == 2'd2) begin
         ndy = 2'd0;
         if (dx_ff == 2'd2) begin
            walk_done = 1'b1;
         end else begin
            ndx = dx_ff + 2'd1;
         end
      end
   end

   assign mul_sel_y = (state_ff == S_KY);
   assign mul_op    = mul_sel_y ? ny : nx;

   shg_hash_mul u_mul (
      .clock   (clock),
      .sel_y   (mul_sel_y),
      .operand (mul_op),
      .prod    (prod)
   );

   assign fill_raddr = key_c[BUCKET_BITS-1:0];

   shg_ram #(.WIDTH(FILL_BITS), .DEPTH(BUCKET_COUNT)) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (bucket),
      .wdata (fill_wdata),
      .raddr (fill_raddr),
      .rdata (fill_rdata)
   );

   shg_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_addr),
      .wdata (slot_wdata),
      .raddr (slot_addr),
      .rdata (slot_rdata)
   );

   always_comb begin
      state_in = state_ff;
      cell_shift_in = csr_we ? csr_wdata : cell_shift_ff;
      op_in = op_ff;
      id_in = id_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      ins_in = ins_ff;
      px_in = px_ff;
      key_in = key_ff;
      fill_in = fill_ff;
      i_in = i_ff;
      any_in = any_ff;
      full_in = full_ff;
      held_in = held_ff;
      have_in = have_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      fvalid_in = fvalid_ff;
      fill_we = 1'b0;
      fill_wdata = '0;
      slot_we = 1'b0;
      slot_idx = i_ff;
      slot_wdata = {key_ff, id_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_item.op;
               id_in = req_item.obj_id;
               cx_in = {{8{sx[23]}}, sx};
               cy_in = {{8{sy[23]}}, sy};
               any_in = 1'b0;
               full_in = 1'b0;
               have_in = 1'b0;
               if (req_item.op == OP_INSERT) begin
                  ins_in = 1'b1;
                  dx_in = 2'd1;
                  dy_in = 2'd1;
                  state_in = S_KX;
               end else if (req_item.op == OP_REMOVE || req_item.op == OP_QUERY ||
                            req_item.op == OP_MOVED) begin
                  ins_in = 1'b0;
                  dx_in = 2'd0;
                  dy_in = 2'd0;
                  state_in = S_KX;
               end else begin
                  if (req_item.op == OP_CLEAR) begin
                     fvalid_in = '0;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_KX: begin
            state_in = S_KY;
         end
         S_KY: begin
            px_in = prod;
            state_in = S_KEY;
         end
         S_KEY: begin
            key_in = key_c;
            state_in = S_FILL;
         end
         S_FILL: begin
            fill_in = fill_cur;
            i_in = '0;
            state_in = ins_ff ? S_INS : S_SLOT;
         end
         S_SLOT: begin
            if (i_ff == fill_ff) begin
               dx_in = ndx;
               dy_in = ndy;
               if (!walk_done) begin
                  state_in = S_KX;
               end else if (op_ff == OP_MOVED) begin
                  ins_in = 1'b1;
                  dx_in = 2'd1;
                  dy_in = 2'd1;
                  state_in = S_KX;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (op_ff == OP_QUERY) begin
               if (rkey == key_ff) begin
                  if (have_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{found_id: held_ff, found: 1'b1, status: ST_OK, last: 1'b0};
                  end
                  held_in = rid;
                  have_in = 1'b1;
               end
               i_in = i_p1[FILL_BITS-1:0];
               state_in = S_SLOT;
            end else if (rkey == key_ff && rid == id_ff) begin
               any_in = 1'b1;
               state_in = (i_p1 < {1'b0, fill_ff}) ? S_SHRD : S_FWR;
            end else begin
               i_in = i_p1[FILL_BITS-1:0];
               state_in = S_SLOT;
            end
         end
         S_SHRD: begin
            slot_idx = i_p1[FILL_BITS-1:0];
            state_in = S_SHWR;
         end
         S_SHWR: begin
            // compaction: move the following entry down one slot
            slot_we = 1'b1;
            slot_wdata = slot_rdata;
            i_in = i_p1[FILL_BITS-1:0];
            state_in = (i_p2 < {1'b0, fill_ff}) ? S_SHRD : S_FWR;
         end
         S_FWR: begin
            fill_we = 1'b1;
            fill_wdata = fill_ff - 1'b1;
            fvalid_in[bucket] = 1'b1;
            // force the neighbor step on the next slot-state visit
            i_in = fill_ff;
            state_in = S_SLOT;
         end
         S_INS: begin
            if ({1'b0, fill_ff} >= (FILL_BITS+1)'(SLOTS_PER_BUCKET)) begin
               full_in = 1'b1;
            end else begin
               slot_idx = fill_ff;
               slot_we = 1'b1;
               fill_we = 1'b1;
               fill_wdata = fill_ff + 1'b1;
               fvalid_in[bucket] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{found_id: '0, found: 1'b0, status: ST_OK, last: 1'b1};
            case (op_ff)
               OP_QUERY: begin
                  if (have_ff) begin
                     rsp_in.found_id = held_ff;
                     rsp_in.found = 1'b1;
                  end
               end
               OP_INSERT: rsp_in.status = full_ff ? ST_FULL : ST_OK;
               OP_REMOVE: rsp_in.status = any_ff ? ST_OK : ST_NO_MATCH;
               OP_MOVED: begin
                  rsp_in.status = full_ff ? ST_FULL : (any_ff ? ST_OK : ST_NO_MATCH);
               end
               default: rsp_in.status = ST_OK;
            endcase
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cell_shift_ff <= CELL_SHIFT_RESET;
         fvalid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cell_shift_ff <= cell_shift_in;
         fvalid_ff <= fvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      ins_ff <= ins_in;
      px_ff <= px_in;
      key_ff <= key_in;
      fill_ff <= fill_in;
      i_ff <= i_in;
      any_ff <= any_in;
      full_ff <= full_in;
      held_ff <= held_in;
      have_ff <= have_in;
      rsp_ff <= rsp_in;
      fvq_ff <= fvalid_ff[fill_raddr];
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
endmodule

// ===== sv/shg_checker.sv =====
// port-level checks of the spatial hash grid engine, bound to the top level
// depends on shg_pkg and assert_macros.svh
`include "assert_macros.svh"

module shg_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input shg_pkg::rsp_type rsp_item
);
   import shg_pkg::*;

   `ASSERT_CLK(a_busy_after_start, clock, reset, (start && !busy) |=> busy)
   `ASSERT_RSP(a_last_ends_busy, clock, reset, (rsp_valid && rsp_item.last) |-> !busy)
   `ASSERT_RSP(a_mid_result_busy, clock, reset, (rsp_valid && !rsp_item.last) |-> busy)
   `ASSERT_RSP(a_found_ok, clock, reset, (rsp_valid && rsp_item.found) |-> (rsp_item.status == ST_OK))
endmodule

bind spatial_hash_grid_engine shg_checker u_shg_checker (.*);
